// ===== design/mixed_precision_accumulate_add_top_assert.svh =====
// Assertion macros for the accumulate-add block.
// Used by the top level; no other dependencies.
`ifndef MIXED_PRECISION_ACCUMULATE_ADD_TOP_ASSERT_SVH
`define MIXED_PRECISION_ACCUMULATE_ADD_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MPA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define MPA_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: label");
`else
`define MPA_ASSERT(label, clk, rst, prop)
`define MPA_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== design/mpa_pkg.sv =====
// Package for the accumulate-add block: float constants and types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mpa_pkg;
   localparam logic [31:0] F32_INF     = 32'h7f800000;
   localparam logic [31:0] F32_QUIET   = 32'h00400000;
   localparam logic [31:0] F32_DEF_NAN = 32'hffc00000;
   localparam logic [15:0] H16_INF     = 16'h7c00;
   localparam logic [15:0] H16_QNAN    = 16'h7e00;
   localparam int          BIAS_GAP    = 127 - 15;

   typedef struct packed {
      logic [31:0] dest_value;
      logic [31:0] addend;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [31:0] new_value;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

// ===== design/mpa_stream_if.sv =====
// Valid/ready stream interface, generic payload width.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface mpa_stream_if #(parameter int W = 1) (input wire logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/mpa_pipe.sv =====
// Five-stage pipelined binary32 add with optional binary16 widen/narrow.
// Depends on mpa_pkg. Stall freezes all stages.
`timescale 1ns / 1ps
`default_nettype none
module mpa_pipe
   import mpa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire logic        half,
   input  wire req_type     in_item,
   output logic             out_valid,
   output rsp_type          out_item
);
   // stage valids
   logic [4:0] v_ff;
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (en) v_ff <= {v_ff[3:0], in_valid};
   end
   assign out_valid = v_ff[4];

   // ---- stage 1: widen half, special cases, swap
   function automatic logic [31:0] widen(input logic [15:0] h);
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [3:0]  lz;
      logic [10:0] sm;
      ex = h[14:10];
      man = h[9:0];
      lz = 4'd0;
      for (int i = 9; i >= 0; i--) if (man[i] && lz == 4'd0 && man >> (i + 1) == 10'd0)
         lz = 4'(10 - i);
      if (ex == 5'd0) begin
         if (man == 10'd0) return {h[15], 31'd0};
         sm = {1'b0, man} << lz;
         return {h[15], 8'(8'd113 - 8'(lz)), sm[9:0], 13'd0};
      end
      if (ex == 5'd31)
         return {h[15], 8'hff, man, 13'd0} | ((man != 10'd0) ? F32_QUIET : 32'd0);
      return {h[15], 8'(ex) + 8'(BIAS_GAP), man, 13'd0};
   endfunction

   logic [31:0] a0, b0, a1_in, b1_in, sp1_in;
   logic        spec1_in;
   always_comb begin
      a0 = half ? widen(in_item.dest_value[15:0]) : in_item.dest_value;
      b0 = in_item.addend;
      spec1_in = 1'b1;
      sp1_in = 32'd0;
      if (a0[30:0] > F32_INF[30:0]) sp1_in = a0 | F32_QUIET;
      else if (b0[30:0] > F32_INF[30:0]) sp1_in = b0 | F32_QUIET;
      else if (a0[30:0] == F32_INF[30:0])
         sp1_in = (b0[30:0] == F32_INF[30:0] && (a0[31] ^ b0[31])) ? F32_DEF_NAN : a0;
      else if (b0[30:0] == F32_INF[30:0]) sp1_in = b0;
      else spec1_in = 1'b0;
      if (b0[30:0] > a0[30:0]) begin a1_in = b0; b1_in = a0; end
      else begin a1_in = a0; b1_in = b0; end
   end

   logic [31:0] a1_ff, b1_ff, sp1_ff;
   logic        spec1_ff, half1_ff, last1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff <= a1_in; b1_ff <= b1_in; sp1_ff <= sp1_in;
         spec1_ff <= spec1_in; half1_ff <= half; last1_ff <= in_item.last;
      end
   end

   // ---- stage 2: align and add
   logic [7:0]  ea, eb, d;
   logic [31:0] ma, mb, mbs;
   logic [32:0] m2_in;
   logic        zero2_in;
   always_comb begin
      ea = (a1_ff[30:23] == 8'd0) ? 8'd1 : a1_ff[30:23];
      eb = (b1_ff[30:23] == 8'd0) ? 8'd1 : b1_ff[30:23];
      ma = {(a1_ff[30:23] != 8'd0), a1_ff[22:0], 8'd0};
      mb = {(b1_ff[30:23] != 8'd0), b1_ff[22:0], 8'd0};
      d = ea - eb;
      if (d >= 8'd32) mbs = {31'd0, (mb != 32'd0)};
      else mbs = (mb >> d) | {31'd0, ((mb & ((32'd1 << d) - 32'd1)) != 32'd0)};
      m2_in = (a1_ff[31] == b1_ff[31]) ? {1'b0, ma} + {1'b0, mbs} : {1'b0, ma} - {1'b0, mbs};
      zero2_in = (m2_in == 33'd0);
   end

   logic [32:0] m2_ff;
   logic [7:0]  e2_ff;
   logic        s2_ff, z2_ff, zs2_ff, spec2_ff, half2_ff, last2_ff;
   logic [31:0] sp2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         m2_ff <= m2_in; e2_ff <= ea; s2_ff <= a1_ff[31]; z2_ff <= zero2_in;
         zs2_ff <= a1_ff[31] & b1_ff[31]; spec2_ff <= spec1_ff; sp2_ff <= sp1_ff;
         half2_ff <= half1_ff; last2_ff <= last1_ff;
      end
   end

   // ---- stage 3: normalize (carry, then left shift limited by exponent)
   logic [31:0] mc, m3_in;
   logic [8:0]  ec, e3_in;
   logic [5:0]  lz3;
   always_comb begin
      if (m2_ff[32]) begin mc = m2_ff[32:1] | {31'd0, m2_ff[0]}; ec = {1'b0, e2_ff} + 9'd1; end
      else begin mc = m2_ff[31:0]; ec = {1'b0, e2_ff}; end
      lz3 = 6'd32;
      for (int i = 0; i < 32; i++) if (mc[i]) lz3 = 6'(31 - i);
      if ({3'd0, lz3} > ec - 9'd1) lz3 = 6'(ec - 9'd1);
      m3_in = mc << lz3;
      e3_in = ec - {3'd0, lz3};
   end

   logic [31:0] m3_ff, sp3_ff;
   logic [8:0]  e3_ff;
   logic        s3_ff, z3_ff, zs3_ff, spec3_ff, half3_ff, last3_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         m3_ff <= m3_in; e3_ff <= e3_in; s3_ff <= s2_ff; z3_ff <= z2_ff; zs3_ff <= zs2_ff;
         spec3_ff <= spec2_ff; sp3_ff <= sp2_ff; half3_ff <= half2_ff; last3_ff <= last2_ff;
      end
   end

   // ---- stage 4: round to binary32
   logic [24:0] q4;
   logic [8:0]  e4;
   logic [31:0] r4_in;
   always_comb begin
      q4 = {1'b0, m3_ff[31:8]};
      if (m3_ff[7:0] > 8'h80 || (m3_ff[7:0] == 8'h80 && q4[0])) q4 = q4 + 25'd1;
      e4 = e3_ff;
      if (q4[24]) begin q4 = q4 >> 1; e4 = e4 + 9'd1; end
      if (spec3_ff) r4_in = sp3_ff;
      else if (z3_ff) r4_in = {zs3_ff, 31'd0};
      else if (e4 >= 9'd255) r4_in = {s3_ff, 31'h7f800000};
      else r4_in = {s3_ff, (q4[23] ? e4[7:0] : 8'd0), q4[22:0]};
   end

   logic [31:0] r4_ff;
   logic        half4_ff, last4_ff;
   always_ff @(posedge clock) begin
      if (en) begin r4_ff <= r4_in; half4_ff <= half3_ff; last4_ff <= last3_ff; end
   end

   // ---- stage 5: narrow to binary16
   logic [15:0] h5;
   logic [15:0] sg;
   logic [8:0]  ne;
   logic [23:0] mh;
   logic [4:0]  sh;
   logic [23:0] qn, rm, hf;
   logic [10:0] qq;
   always_comb begin
      sg = {r4_ff[31], 15'd0};
      ne = {1'b0, r4_ff[30:23]} - 9'(BIAS_GAP);   // signed 9-bit
      mh = {1'b1, r4_ff[22:0]};
      sh = 5'(9'd14 - ne);
      qn = mh >> sh;
      rm = mh & ((24'd1 << sh) - 24'd1);
      hf = 24'd1 << (sh - 5'd1);
      qq = {1'b0, r4_ff[22:13]};
      if (r4_ff[30:23] == 8'hff)
         h5 = (r4_ff[22:0] == 23'd0) ? (sg | H16_INF) : (sg | H16_QNAN | {6'd0, r4_ff[22:13]});
      else if (!ne[8] && ne >= 9'd31) h5 = sg | H16_INF;
      else if (ne[8] || ne == 9'd0) begin
         if ($signed(ne) < -9'sd10) h5 = sg;
         else begin
            if (rm > hf || (rm == hf && qn[0])) qn = qn + 24'd1;
            h5 = sg | qn[15:0];
         end
      end else begin
         if (r4_ff[12:0] > 13'h1000 || (r4_ff[12:0] == 13'h1000 && qq[0])) qq = qq + 11'd1;
         if (qq[10]) h5 = (ne + 9'd1 >= 9'd31) ? (sg | H16_INF) : (sg | {ne[4:0] + 5'd1, 10'd0});
         else h5 = sg | {ne[4:0], qq[9:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_item.new_value <= half4_ff ? {16'd0, h5} : r4_ff;
         out_item.last <= last4_ff;
      end
   end
endmodule
`default_nettype wire

// ===== design/mixed_precision_accumulate_add_top.sv =====
// Throughput: one item per cycle while rsp is not held back (see stall below).
// Pipeline is a single stall domain: when rsp is held and the last stage is full,
// all stages freeze, bubbles included; with the last stage empty everything advances.
// Reset: synchronous active high; clears stage valids and sets half_ff to 0.
// Top level: channels, config register, pipe instance. Depends on mpa_pkg,
// mpa_stream_if, mpa_pipe and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "mixed_precision_accumulate_add_top_assert.svh"
module mixed_precision_accumulate_add_top
   import mpa_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mpa_stream_if.sink   req,
   mpa_stream_if.sink   csr,
   mpa_stream_if.source rsp
);
   logic half_ff;
   logic en, pv;
   req_type ri;
   rsp_type ro;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) half_ff <= 1'b0;
      else if (csr.valid) half_ff <= csr.data[0];
   end

   assign en = !pv || rsp.ready;
   assign req.ready = en;
   assign ri = req_type'(req.data);

   mpa_pipe u_pipe (
      .clock(clock), .reset(reset), .en(en), .in_valid(req.valid), .half(half_ff),
      .in_item(ri), .out_valid(pv), .out_item(ro)
   );
   assign rsp.valid = pv;
   assign rsp.data = ro;

   `MPA_ASSERT(a_stall_hold, clock, reset, (rsp.valid && !rsp.ready) |=> rsp.valid)
   `MPA_ASSERT(a_ready_free, clock, reset, !rsp.valid |-> req.ready)
   `MPA_ASSERT(a_half_upper0, clock, reset, (rsp.valid && $past(half_ff, 5) && $past(en, 1) && $past(en, 2) && $past(en, 3) && $past(en, 4) && $past(en, 5)) |-> rsp.data[32:17] == 16'd0)
endmodule
`default_nettype wire
